// File: hw/rtl/smbc_pkg.sv
// Shared types and constants for the setup menu blink controller.
// Used by smbc_div, smbc_blink and setup_menu_blink_controller_unit.
// Depends on nothing.
`default_nettype none

package smbc_pkg;

  // Field and timer widths.
  localparam int TIMER_W   = 16;
  localparam int ELAPSED_W = 8;
  localparam int KEYS_W    = 13;
  localparam int QUICK_W   = 9;
  localparam int MODE_W    = 3;
  localparam int SPEED_W   = 7;
  localparam int ITEM_W    = 2;
  localparam int VALUE_W   = 8;
  localparam int PHASES_W  = VALUE_W + 1;

  // Shared divider: unsigned, one quotient bit per cycle.
  localparam int DIV_W     = 16;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // Menu layout and setting limits.
  localparam int MENU_ITEMS = 3;
  localparam logic [ITEM_W-1:0]  ITEM_MODE  = 2'd0;
  localparam logic [ITEM_W-1:0]  ITEM_SWAP  = 2'd1;
  localparam logic [ITEM_W-1:0]  ITEM_SPEED = 2'd2;
  localparam logic [MODE_W-1:0]  MODE_MAX   = 3'd5;
  localparam logic [SPEED_W-1:0] SPEED_MAX  = 7'd127;
  localparam logic [SPEED_W-1:0] SPEED_MIN  = 7'd1;
  localparam logic [TIMER_W-1:0] TIMER_MAX  = 16'hFFFF;
  localparam logic [VALUE_W-1:0] WIDE_VALUE = 8'd255;
  localparam logic [VALUE_W-1:0] STEADY_LIMIT = 8'd5;

  // Key vector layout.
  localparam int KEY_SETUP  = 0;
  localparam int KEY_SELECT = 1;
  localparam int KEY_LEFT   = 2;
  localparam int KEY_RIGHT  = 3;
  localparam int KEY_QUICK  = 4;

  // Quick keys with a special meaning; keys one to five pick that mode.
  localparam int QK_RESET    = 0;
  localparam int QK_MODE_LO  = 1;
  localparam int QK_MODE_HI  = 5;
  localparam int QK_SWAP     = 6;
  localparam int QK_SPEED_DN = 7;
  localparam int QK_SPEED_UP = 8;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENTER_HOLD    = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLINK_WINDOW  = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SWAP_DEFAULT  = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_DEFAULT = 8'd3;

  // Configuration reset values.
  localparam logic [TIMER_W-1:0] ENTER_HOLD_RST    = 16'd2000;
  localparam logic [TIMER_W-1:0] BLINK_WINDOW_RST  = 16'd2000;
  localparam logic               SWAP_DEFAULT_RST  = 1'b0;
  localparam logic [SPEED_W-1:0] SPEED_DEFAULT_RST = 7'd8;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic               start;
    logic [TIMER_W-1:0] t;
    logic [TIMER_W-1:0] window_ms;
    logic [VALUE_W-1:0] count_a;
    logic [VALUE_W-1:0] count_b;
  } blink_req_t;

  typedef struct packed {
    logic done;
    logic on_a;
    logic on_b;
  } blink_rsp_t;

  // A speed default of zero loads as the lowest speed.
  function automatic logic [SPEED_W-1:0] load_speed(input logic [SPEED_W-1:0] v);
    return (v == '0) ? SPEED_MIN : v;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/smbc_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on smbc_pkg for widths and the request/response structs.
`default_nettype none

module smbc_div import smbc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     quo;
  logic [DIV_W-1:0]     divisor;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [DIV_W:0]       shifted;
  logic [DIV_W+1:0]     diff;

  // Trial subtraction of the divisor from the shifted partial remainder.
  assign shifted = {rem, quo[DIV_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor};

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      quo     <= req.dividend;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= diff[DIV_W+1] ? shifted[DIV_W-1:0] : diff[DIV_W-1:0];
      quo <= {quo[DIV_W-2:0], ~diff[DIV_W+1]};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

// File: hw/rtl/smbc_blink.sv
// Blink code sequencer: evaluates the LED blink test for two counts
// with one shared divider. Depends on smbc_pkg and smbc_div.
`default_nettype none

module smbc_blink import smbc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire blink_req_t req,
  output blink_rsp_t      rsp
);

  typedef enum logic [4:0] {
    B_IDLE    = 5'b00001,
    B_PER_GO  = 5'b00010,
    B_PER_WAIT = 5'b00100,
    B_PH_GO   = 5'b01000,
    B_PH_WAIT = 5'b10000
  } blink_state_t;

  blink_state_t         state;
  logic                 lane;
  logic                 done;
  logic                 on_a;
  logic                 on_b;
  logic [TIMER_W-1:0]   window;
  logic [TIMER_W-1:0]   t;
  logic [PHASES_W-1:0]  phases_a;
  logic [PHASES_W-1:0]  phases_b;
  logic [DIV_W-1:0]     period;
  logic [TIMER_W+1:0]   wsum;
  logic [PHASES_W-1:0]  phases;
  logic                 no_period;
  logic                 phase_on;
  logic                 lane_on;
  logic                 lane_end;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  smbc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Three quarters of the window, rounded down.
  assign wsum = {2'b00, req.window_ms} + {1'b0, req.window_ms, 1'b0};

  assign phases = lane ? phases_b : phases_a;

  // A count below one or a zero period leaves the LED off.
  assign no_period = (div_rsp.quotient == '0) || (phases < PHASES_W'(2));
  // On during even phases that lie inside the code.
  assign phase_on  = ~div_rsp.quotient[0] &&
                     (div_rsp.quotient < {{(DIV_W-PHASES_W){1'b0}}, phases});

  // Divider requests: first the period, then the phase of the sample time.
  always_comb begin
    div_req.start    = (state == B_PER_GO) || (state == B_PH_GO);
    div_req.dividend = (state == B_PER_GO) ? window : t;
    div_req.divisor  = (state == B_PER_GO) ?
                       {{(DIV_W-PHASES_W){1'b0}}, phases} : period;
  end

  // Lane result and whether this lane is finished in the current cycle.
  always_comb begin
    lane_on  = 1'b0;
    lane_end = 1'b0;
    if ((state == B_PER_WAIT) && div_rsp.done && no_period) begin
      lane_end = 1'b1;
    end else if ((state == B_PH_WAIT) && div_rsp.done) begin
      lane_end = 1'b1;
      lane_on  = phase_on;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      lane  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (req.start) begin
            lane  <= 1'b0;
            state <= B_PER_GO;
          end
        end
        B_PER_GO:  state <= B_PER_WAIT;
        B_PER_WAIT: begin
          if (div_rsp.done) begin
            if (!no_period) begin
              state <= B_PH_GO;
            end else if (!lane) begin
              lane  <= 1'b1;
              state <= B_PER_GO;
            end else begin
              done  <= 1'b1;
              state <= B_IDLE;
            end
          end
        end
        B_PH_GO:   state <= B_PH_WAIT;
        B_PH_WAIT: begin
          if (div_rsp.done) begin
            if (!lane) begin
              lane  <= 1'b1;
              state <= B_PER_GO;
            end else begin
              done  <= 1'b1;
              state <= B_IDLE;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // Operands and per-lane results.
  always_ff @(posedge clk) begin
    if ((state == B_IDLE) && req.start) begin
      window   <= wsum[TIMER_W+1:2];
      t        <= req.t;
      phases_a <= {req.count_a, 1'b0};
      phases_b <= {req.count_b, 1'b0};
    end
    if ((state == B_PER_WAIT) && div_rsp.done) begin
      period <= div_rsp.quotient;
    end
    if (lane_end) begin
      if (lane) begin
        on_b <= lane_on;
      end else begin
        on_a <= lane_on;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.on_a = on_a;
  assign rsp.on_b = on_b;

endmodule

`default_nettype wire

// File: hw/rtl/setup_menu_blink_controller_unit.sv
// Setup menu blink controller, top level: handshakes, menu state, LEDs.
// Depends on smbc_pkg and smbc_blink (which holds the shared divider).
//
// Usage: one input beat per key poll carries the key levels and the
// milliseconds since the last poll; each poll gives exactly one output
// beat with the LED levels, the current settings and the menu state.
// Both channels use valid/ready. The configuration channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data) is always ready; indexes above three
// are ignored. Write it only while no poll is in flight.
// Sequence: a poll that ends before the blink test (setup mode off,
// quick key, select key) goes straight to the emit state, which loads
// the output beat and raises output valid. A poll that runs the blink
// test does per LED one period division and, when that period is nonzero
// and the count is at least one, one phase division. Each division runs
// 16 steps of the one shared restoring divider plus start and hand-off;
// the request, the LED update and the output load come on top.
// Flow: in_ready is high only while the block is idle, so a new poll is
// not taken before the last one has loaded its output beat. The output
// register holds a finished beat while the receiver stalls and the next poll
// may be accepted meanwhile; its result waits until the held beat is taken.
// Reset: settings go to mode 0, the default swap and speed, setup and edit
// mode off, timers and LEDs cleared, configuration to its reset values.
`default_nettype none

module setup_menu_blink_controller_unit import smbc_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // Poll channel.
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   setup_key,
  input  wire logic                   select_key,
  input  wire logic                   left_key,
  input  wire logic                   right_key,
  input  wire logic [QUICK_W-1:0]     quick_keys,
  input  wire logic [ELAPSED_W-1:0]   elapsed_ms,
  // Result channel.
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        led_item,
  output logic                        led_value,
  output logic [MODE_W-1:0]           emulation_mode,
  output logic                        swap_axes,
  output logic [SPEED_W-1:0]          mouse_speed,
  output logic                        setup_active,
  output logic                        edit_active,
  output logic [ITEM_W-1:0]           menu_item,
  // Configuration channel.
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [3:0] {
    T_IDLE = 4'b0001,
    T_RUN  = 4'b0010,
    T_WAIT = 4'b0100,
    T_EMIT = 4'b1000
  } top_state_t;

  top_state_t state;

  // Configuration registers.
  logic [TIMER_W-1:0] enter_hold_ms;
  logic [TIMER_W-1:0] blink_window_ms;
  logic               swap_default;
  logic [SPEED_W-1:0] speed_default;

  // Menu state.
  logic               setup_on, setup_on_next;
  logic               edit_on, edit_on_next;
  logic [ITEM_W-1:0]  item_select, item_select_next;
  logic [KEYS_W-1:0]  last_keys, last_keys_next;
  logic [TIMER_W-1:0] hold_timer, hold_timer_next;
  logic [TIMER_W-1:0] flash_timer, flash_timer_next;
  logic [MODE_W-1:0]  mode_value, mode_value_next;
  logic               swap_value, swap_value_next;
  logic [SPEED_W-1:0] speed_value, speed_value_next;
  logic [1:0]         led_pair, led_pair_next;
  logic [TIMER_W-1:0] sample_t, sample_t_next;
  logic [VALUE_W-1:0] item_val, item_val_next;
  logic               run_blink;

  logic [KEYS_W-1:0]  keys;
  logic [KEYS_W-1:0]  edges;
  logic [QUICK_W-1:0] quick;
  logic [TIMER_W:0]   hold_sum;
  logic [TIMER_W:0]   flash_sum;
  logic               move;
  logic               accept;
  logic               led1;
  logic               led2;

  blink_req_t         blink_req;
  blink_rsp_t         blink_rsp;

  smbc_blink u_blink (
    .clk (clk),
    .rst (rst),
    .req (blink_req),
    .rsp (blink_rsp)
  );

  assign in_ready  = (state == T_IDLE);
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign keys = {quick_keys, right_key, left_key, select_key, setup_key};

  // Timers advance by the elapsed time and saturate.
  assign hold_sum  = {1'b0, hold_timer} + {{(TIMER_W+1-ELAPSED_W){1'b0}}, elapsed_ms};
  assign flash_sum = {1'b0, flash_timer} + {{(TIMER_W+1-ELAPSED_W){1'b0}}, elapsed_ms};

  // One poll of the menu: hold detection, key edges, quick keys and moves.
  always_comb begin
    hold_timer_next  = hold_sum[TIMER_W] ? TIMER_MAX : hold_sum[TIMER_W-1:0];
    flash_timer_next = flash_sum[TIMER_W] ? TIMER_MAX : flash_sum[TIMER_W-1:0];
    setup_on_next    = setup_on;
    edit_on_next     = edit_on;
    item_select_next = item_select;
    last_keys_next   = last_keys;
    led_pair_next    = led_pair;
    mode_value_next  = mode_value;
    swap_value_next  = swap_value;
    speed_value_next = speed_value;
    sample_t_next    = sample_t;
    item_val_next    = item_val;
    run_blink        = 1'b0;
    edges            = '0;
    quick            = '0;
    move             = 1'b0;

    if (!setup_key) begin
      hold_timer_next = '0;
    end

    // A long hold of the setup key clears the menu and toggles setup mode.
    if (hold_timer_next > enter_hold_ms) begin
      last_keys_next   = '0;
      item_select_next = ITEM_MODE;
      edit_on_next     = 1'b0;
      hold_timer_next  = '0;
      flash_timer_next = '0;
      led_pair_next    = '0;
      setup_on_next    = ~setup_on;
    end

    if (setup_on_next) begin
      edges          = keys & ~last_keys_next;
      last_keys_next = keys;
      quick          = edges[KEYS_W-1:KEY_QUICK];

      if ((edges[KEY_QUICK-1:0] == '0) && (quick != '0) &&
          ((quick & (quick - 1'b1)) == '0)) begin
        // A lone quick key edge changes a setting and leaves setup mode.
        if (quick[QK_RESET]) begin
          mode_value_next  = '0;
          swap_value_next  = swap_default;
          speed_value_next = load_speed(speed_default);
        end else if (quick[QK_SWAP]) begin
          swap_value_next = ~swap_value;
        end else if (quick[QK_SPEED_DN]) begin
          if (speed_value > SPEED_MIN) begin
            speed_value_next = speed_value - 1'b1;
          end
        end else if (quick[QK_SPEED_UP]) begin
          if (speed_value < SPEED_MAX) begin
            speed_value_next = speed_value + 1'b1;
          end
        end else begin
          for (int i = QK_MODE_LO; i <= QK_MODE_HI; i++) begin
            if (quick[i]) begin
              mode_value_next = MODE_W'(i);
            end
          end
        end
        last_keys_next   = '0;
        item_select_next = ITEM_MODE;
        setup_on_next    = 1'b0;
        edit_on_next     = 1'b0;
        hold_timer_next  = '0;
        flash_timer_next = '0;
        led_pair_next    = '0;
      end else if (edges[KEY_SELECT]) begin
        edit_on_next = ~edit_on_next;
      end else begin
        // Left and right together cancel out.
        move = edges[KEY_LEFT] ^ edges[KEY_RIGHT];
        if (move && !edit_on_next) begin
          if (edges[KEY_RIGHT] && (item_select_next != ITEM_W'(MENU_ITEMS - 1))) begin
            item_select_next = item_select_next + 1'b1;
          end else if (edges[KEY_LEFT] && (item_select_next != ITEM_MODE)) begin
            item_select_next = item_select_next - 1'b1;
          end
        end
        if (move && edit_on_next) begin
          case (item_select_next)
            ITEM_MODE: begin
              if (edges[KEY_RIGHT] && (mode_value < MODE_MAX)) begin
                mode_value_next = mode_value + 1'b1;
              end else if (edges[KEY_LEFT] && (mode_value != '0)) begin
                mode_value_next = mode_value - 1'b1;
              end
            end
            ITEM_SWAP: swap_value_next = ~swap_value;
            ITEM_SPEED: begin
              if (edges[KEY_RIGHT] && (speed_value < SPEED_MAX)) begin
                speed_value_next = speed_value + 1'b1;
              end else if (edges[KEY_LEFT] && (speed_value > SPEED_MIN)) begin
                speed_value_next = speed_value - 1'b1;
              end
            end
            default: ;
          endcase
        end
        if (move) begin
          flash_timer_next = '0;
        end

        // Sample the blink time, then wrap the window.
        sample_t_next = flash_timer_next;
        if (flash_timer_next > blink_window_ms) begin
          flash_timer_next = '0;
        end

        case (item_select_next)
          ITEM_MODE:  item_val_next = {{(VALUE_W-MODE_W){1'b0}}, mode_value_next};
          ITEM_SWAP:  item_val_next = swap_value_next ? WIDE_VALUE : '0;
          ITEM_SPEED: item_val_next = {{(VALUE_W-SPEED_W){1'b0}}, speed_value_next};
          default:    item_val_next = '0;
        endcase
        run_blink = 1'b1;
      end
    end
  end

  // LED levels from the two blink tests.
  always_comb begin
    led1 = blink_rsp.on_a | edit_on;
    led2 = blink_rsp.on_b;
    if (edit_on) begin
      if (item_val != '0) begin
        led1 = 1'b0;
      end
      if (item_val > STEADY_LIMIT) begin
        led2 = 1'b1;
      end
    end else begin
      led2 = 1'b0;
    end
  end

  always_comb begin
    blink_req.start     = (state == T_RUN);
    blink_req.t         = sample_t;
    blink_req.window_ms = blink_window_ms;
    blink_req.count_a   = VALUE_W'(item_select) + 1'b1;
    blink_req.count_b   = item_val;
  end

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      enter_hold_ms   <= ENTER_HOLD_RST;
      blink_window_ms <= BLINK_WINDOW_RST;
      swap_default    <= SWAP_DEFAULT_RST;
      speed_default   <= SPEED_DEFAULT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ENTER_HOLD:    enter_hold_ms   <= cfg_data;
        CFG_BLINK_WINDOW:  blink_window_ms <= cfg_data;
        CFG_SWAP_DEFAULT:  swap_default    <= cfg_data[0];
        CFG_SPEED_DEFAULT: speed_default   <= cfg_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and menu state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= T_IDLE;
      out_valid   <= 1'b0;
      setup_on    <= 1'b0;
      edit_on     <= 1'b0;
      item_select <= ITEM_MODE;
      last_keys   <= '0;
      hold_timer  <= '0;
      flash_timer <= '0;
      mode_value  <= '0;
      swap_value  <= SWAP_DEFAULT_RST;
      speed_value <= load_speed(SPEED_DEFAULT_RST);
      led_pair    <= '0;
    end else begin
      // Output valid rises when a beat is loaded and falls once it is taken.
      if ((state == T_EMIT) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            setup_on    <= setup_on_next;
            edit_on     <= edit_on_next;
            item_select <= item_select_next;
            last_keys   <= last_keys_next;
            hold_timer  <= hold_timer_next;
            flash_timer <= flash_timer_next;
            mode_value  <= mode_value_next;
            swap_value  <= swap_value_next;
            speed_value <= speed_value_next;
            led_pair    <= led_pair_next;
            state       <= run_blink ? T_RUN : T_EMIT;
          end
        end
        T_RUN:  state <= T_WAIT;
        T_WAIT: begin
          if (blink_rsp.done) begin
            led_pair <= {led2, led1};
            state    <= T_EMIT;
          end
        end
        T_EMIT: begin
          if (!out_valid || out_ready) begin
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  // Blink operands and the output beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_t <= sample_t_next;
      item_val <= item_val_next;
    end
    if ((state == T_EMIT) && (!out_valid || out_ready)) begin
      led_item       <= led_pair[0];
      led_value      <= led_pair[1];
      emulation_mode <= mode_value;
      swap_axes      <= swap_value;
      mouse_speed    <= speed_value;
      setup_active   <= setup_on;
      edit_active    <= edit_on;
      menu_item      <= item_select;
    end
  end

  // The mode never leaves its range.
  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (emulation_mode <= MODE_MAX))
    else $error("emulation mode out of range");

  // Mouse speed never reaches zero.
  a_speed_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (mouse_speed != '0))
    else $error("mouse speed is zero");

  // Edit mode exists only inside setup mode, on a valid item.
  a_edit_in_setup: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((!edit_active || setup_active) &&
                   (menu_item != ITEM_W'(MENU_ITEMS))))
    else $error("edit mode or menu item inconsistent");

  // The blink sequencer finishes only while the top waits for it.
  a_blink_done: assert property (@(posedge clk) disable iff (rst)
    blink_rsp.done |-> (state == T_WAIT))
    else $error("blink result without a request");

endmodule

`default_nettype wire

// File: sim/tb_setup_menu_blink_controller_unit.sv
`timescale 1ns / 100ps
// Testbench for setup_menu_blink_controller_unit: directed and random key polls, each
// status beat checked against a behavioral predictor of the menu, settings and LEDs.
// Depends on smbc_pkg and the RTL of the block; reads no files.

module tb_setup_menu_blink_controller_unit;
  import smbc_pkg::*;

  // Register indexes the block must ignore.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 8'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 8'd255;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic                 setup;
    logic                 select;
    logic                 left;
    logic                 right;
    logic [QUICK_W-1:0]   quick;
    logic [ELAPSED_W-1:0] elapsed;
  } poll_t;

  typedef struct packed {
    logic               led_item;
    logic               led_value;
    logic [MODE_W-1:0]  mode;
    logic               swap;
    logic [SPEED_W-1:0] speed;
    logic               setup;
    logic               edit;
    logic [ITEM_W-1:0]  item;
  } menu_status_t;

  typedef struct {
    poll_t        poll;
    bit           fixed;
    menu_status_t want;
  } menu_row_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   in_valid;
  logic                   in_ready;
  logic                   setup_key;
  logic                   select_key;
  logic                   left_key;
  logic                   right_key;
  logic [QUICK_W-1:0]     quick_keys;
  logic [ELAPSED_W-1:0]   elapsed_ms;
  logic                   out_valid;
  logic                   out_ready;
  logic                   led_item;
  logic                   led_value;
  logic [MODE_W-1:0]      emulation_mode;
  logic                   swap_axes;
  logic [SPEED_W-1:0]     mouse_speed;
  logic                   setup_active;
  logic                   edit_active;
  logic [ITEM_W-1:0]      menu_item;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Predicted configuration.
  logic [TIMER_W-1:0] hold_limit   = ENTER_HOLD_RST;
  logic [TIMER_W-1:0] blink_window = BLINK_WINDOW_RST;
  logic               swap_dflt    = SWAP_DEFAULT_RST;
  logic [SPEED_W-1:0] speed_dflt   = SPEED_DEFAULT_RST;

  // Predicted menu state and settings.
  logic               menu_on  = 1'b0;
  logic               edit_on  = 1'b0;
  logic [ITEM_W-1:0]  item_sel = ITEM_MODE;
  logic [KEYS_W-1:0]  key_hist = '0;
  logic [TIMER_W-1:0] hold_ms  = '0;
  logic [TIMER_W-1:0] blink_ms = '0;
  logic [MODE_W-1:0]  mode_q   = '0;
  logic               swap_q   = SWAP_DEFAULT_RST;
  logic [SPEED_W-1:0] speed_q  = SPEED_DEFAULT_RST;
  logic [1:0]         leds     = '0;

  menu_status_t status_due[$];
  int           mismatches = 0;
  bit           steady_in  = 1'b0;
  bit           steady_out = 1'b0;

  setup_menu_blink_controller_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .setup_key      (setup_key),
    .select_key     (select_key),
    .left_key       (left_key),
    .right_key      (right_key),
    .quick_keys     (quick_keys),
    .elapsed_ms     (elapsed_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .led_item       (led_item),
    .led_value      (led_value),
    .emulation_mode (emulation_mode),
    .swap_axes      (swap_axes),
    .mouse_speed    (mouse_speed),
    .setup_active   (setup_active),
    .edit_active    (edit_active),
    .menu_item      (menu_item),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Saturating millisecond timer add.
  function automatic logic [TIMER_W-1:0] add_ms(logic [TIMER_W-1:0] a,
                                                logic [ELAPSED_W-1:0] b);
    int unsigned s;
    s = a + b;
    return (s > TIMER_MAX) ? TIMER_MAX : s[TIMER_W-1:0];
  endfunction

  // Blink code of count flashes spread over three quarters of the window.
  function automatic bit blink_on(int unsigned t, int unsigned count);
    int unsigned window;
    int unsigned phases;
    int unsigned period;
    int unsigned slot;
    window = (blink_window * 3) >> 2;
    phases = count << 1;
    if (phases < 2) return 1'b0;
    period = window / phases;
    if (period == 0) return 1'b0;
    slot = t / period;
    return (slot % 2 == 0) && (slot < phases);
  endfunction

  function automatic void clear_menu();
    key_hist = '0;
    item_sel = ITEM_MODE;
    menu_on  = 1'b0;
    edit_on  = 1'b0;
    hold_ms  = '0;
    blink_ms = '0;
    leds     = '0;
  endfunction

  // Moves the setting of the chosen item, holding it within its range.
  function automatic void nudge_setting(int amount);
    int m;
    case (item_sel)
      ITEM_MODE: begin
        m = int'(mode_q) + amount;
        if (m >= 0 && m <= int'(MODE_MAX)) mode_q = MODE_W'(m);
      end
      ITEM_SWAP: swap_q = !swap_q;
      ITEM_SPEED: begin
        m = int'(speed_q) + amount;
        if (m >= int'(SPEED_MIN) && m <= int'(SPEED_MAX)) speed_q = SPEED_W'(m);
      end
      default: ;
    endcase
  endfunction

  function automatic menu_status_t status_now();
    return {leds[0], leds[1], mode_q, swap_q, speed_q, menu_on, edit_on, item_sel};
  endfunction

  function automatic void apply_register(logic [CFG_INDEX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_ENTER_HOLD:    hold_limit   = data;
      CFG_BLINK_WINDOW:  blink_window = data;
      CFG_SWAP_DEFAULT:  swap_dflt    = data[0];
      CFG_SPEED_DEFAULT: speed_dflt   = data[SPEED_W-1:0];
      default: ;
    endcase
  endfunction

  // Advances the predicted menu by one poll and returns the status it shows.
  function automatic menu_status_t step_menu(poll_t p);
    logic [KEYS_W-1:0]  keys;
    logic [KEYS_W-1:0]  edges;
    logic [QUICK_W-1:0] fresh;
    int                 delta;
    int                 ni;
    int                 k;
    int unsigned        t;
    int unsigned        v;
    bit                 l1;
    bit                 l2;
    bit                 was;
    keys = {p.quick, p.right, p.left, p.select, p.setup};
    hold_ms  = add_ms(hold_ms, p.elapsed);
    blink_ms = add_ms(blink_ms, p.elapsed);
    if (!p.setup) hold_ms = '0;

    // A long enough hold of the setup key toggles setup mode.
    if (hold_ms > hold_limit) begin
      was = menu_on;
      clear_menu();
      menu_on = !was;
    end
    if (!menu_on) return status_now();

    edges = keys & ~key_hist;
    key_hist = keys;
    fresh = edges[KEYS_W-1:KEY_QUICK];

    // A quick key acts only when it is the single new press of the poll.
    k = 0;
    if (edges[KEY_QUICK-1:0] == '0 && fresh != '0 && (fresh & (fresh - 1'b1)) == '0) begin
      for (int i = 0; i < QUICK_W; i++) if (fresh[i]) k = i;
      if (k == QK_RESET) begin
        mode_q  = '0;
        swap_q  = swap_dflt;
        speed_q = (speed_dflt == '0) ? SPEED_MIN : speed_dflt;
      end else if (k <= QK_MODE_HI) begin
        mode_q = MODE_W'(k);
      end else if (k == QK_SWAP) begin
        item_sel = ITEM_SWAP;
        nudge_setting(1);
      end else if (k == QK_SPEED_DN) begin
        item_sel = ITEM_SPEED;
        nudge_setting(-1);
      end else begin
        item_sel = ITEM_SPEED;
        nudge_setting(1);
      end
      clear_menu();
      return status_now();
    end

    // Select flips edit mode and leaves the LEDs as they were.
    if (edges[KEY_SELECT]) begin
      edit_on = !edit_on;
      return status_now();
    end

    // Left and right move the cursor, or change the setting in edit mode.
    delta = int'(edges[KEY_RIGHT]) - int'(edges[KEY_LEFT]);
    if (!edit_on) begin
      ni = int'(item_sel) + delta;
      if (ni >= 0 && ni < MENU_ITEMS) item_sel = ITEM_W'(ni);
    end else if (delta != 0) begin
      nudge_setting(delta);
    end
    if (delta != 0) blink_ms = '0;

    // Sample the blink time, then restart the window once it has run out.
    t = blink_ms;
    if (blink_ms > blink_window) blink_ms = '0;
    case (item_sel)
      ITEM_MODE:  v = mode_q;
      ITEM_SWAP:  v = swap_q ? WIDE_VALUE : 0;
      ITEM_SPEED: v = speed_q;
      default:    v = 0;
    endcase
    l1 = blink_on(t, item_sel + 1) || edit_on;
    l2 = blink_on(t, v);
    if (edit_on) begin
      if (v != 0) l1 = 1'b0;
      if (v > STEADY_LIMIT) l2 = 1'b1;
    end else begin
      l2 = 1'b0;
    end
    leds = {l2, l1};
    return status_now();
  endfunction

  function automatic poll_t key_poll(bit s, bit sel, bit l, bit r, logic [QUICK_W-1:0] q,
                                     logic [ELAPSED_W-1:0] e);
    return {s, sel, l, r, q, e};
  endfunction

  // Random poll shaped by the predicted mode: outside the menu mostly a long
  // setup hold, inside mostly single presses separated by releases.
  function automatic poll_t next_poll();
    poll_t p;
    int    pick;
    p = '0;
    pick = $urandom_range(0, 99);
    if (!menu_on) begin
      if (pick < 60) begin
        p.setup   = 1'b1;
        p.elapsed = ELAPSED_W'($urandom_range(128, 255));
        if (pick < 15) p.quick = QUICK_W'($urandom);
      end else begin
        p = $bits(poll_t)'($urandom);
      end
    end else begin
      p.elapsed = $urandom_range(0, 1) ? ELAPSED_W'($urandom_range(0, 40))
                                       : ELAPSED_W'($urandom_range(0, 255));
      if (pick >= 96) begin
        p = $bits(poll_t)'($urandom);
      end else if (pick >= 92) begin
        p.setup   = 1'b1;
        p.elapsed = ELAPSED_W'($urandom_range(128, 255));
      end else if (pick >= 88) begin
        p.quick = QUICK_W'($urandom);
      end else if (pick >= 78) begin
        p.quick = QUICK_W'(1) << $urandom_range(0, QUICK_W - 1);
      end else if (pick >= 75) begin
        p.left  = 1'b1;
        p.right = 1'b1;
      end else if (pick >= 60) begin
        p.left = 1'b1;
      end else if (pick >= 45) begin
        p.right = 1'b1;
      end else if (pick >= 35) begin
        p.select = 1'b1;
      end
    end
    return p;
  endfunction

  function automatic string show_status(menu_status_t s);
    return $sformatf("leds %0d/%0d mode %0d swap %0d speed %0d setup %0d edit %0d item %0d",
                     s.led_item, s.led_value, s.mode, s.swap, s.speed, s.setup, s.edit,
                     s.item);
  endfunction

  // Drives one poll beat from a falling edge and records its expected status.
  task automatic send_poll(poll_t p, bit fixed, menu_status_t want);
    int           gap;
    menu_status_t got;
    if ($urandom_range(0, 29) == 0) steady_in = !steady_in;
    gap = steady_in ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    {setup_key, select_key, left_key, right_key, quick_keys, elapsed_ms} <= p;
    do @(posedge clk); while (!in_ready);
    got = step_menu(p);
    status_due.push_back(fixed ? want : got);
    @(negedge clk);
  endtask

  task automatic run_polls(int count);
    repeat (count) send_poll(next_poll(), 1'b0, '0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(negedge clk);
  endtask

  // Writes all four registers back to back, then one index that must be ignored.
  task automatic reconfigure(logic [CFG_DATA_W-1:0] hold, logic [CFG_DATA_W-1:0] window,
                             logic [CFG_DATA_W-1:0] swapd, logic [CFG_DATA_W-1:0] speedd,
                             logic [CFG_INDEX_W-1:0] spare, logic [CFG_DATA_W-1:0] junk);
    logic [CFG_INDEX_W-1:0] idx[5];
    logic [CFG_DATA_W-1:0]  val[5];
    idx = '{CFG_ENTER_HOLD, CFG_BLINK_WINDOW, CFG_SWAP_DEFAULT, CFG_SPEED_DEFAULT, spare};
    val = '{hold, window, swapd, speedd, junk};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      apply_register(idx[i], val[i]);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stimulus: directed opening, then configuration phases with random polls.
  initial begin
    menu_row_t    opening_polls[$];
    menu_status_t reset_view;
    rst        = 1'b1;
    in_valid   = 1'b0;
    setup_key  = 1'b0;
    select_key = 1'b0;
    left_key   = 1'b0;
    right_key  = 1'b0;
    quick_keys = '0;
    elapsed_ms = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    reset_view = {1'b0, 1'b0, MODE_W'(0), SWAP_DEFAULT_RST, SPEED_DEFAULT_RST,
                  1'b0, 1'b0, ITEM_MODE};

    // Idle poll and every key held at the longest step still show the reset state.
    opening_polls.push_back('{key_poll(0, 0, 0, 0, '0, 0), 1'b1, reset_view});
    opening_polls.push_back('{key_poll(1, 1, 1, 1, '1, 8'hFF), 1'b1, reset_view});
    // Keep holding setup until the hold time is passed and the menu opens.
    repeat (7) opening_polls.push_back('{key_poll(1, 0, 0, 0, '0, 8'hFF), 1'b0, reset_view});
    opening_polls.push_back('{key_poll(0, 0, 0, 0, '0, 0), 1'b0, reset_view});
    // Two quick keys at once do nothing.
    opening_polls.push_back('{key_poll(0, 0, 0, 0,
                              (QUICK_W'(1) << QK_MODE_LO) | (QUICK_W'(1) << QK_MODE_HI), 10),
                              1'b0, reset_view});
    opening_polls.push_back('{key_poll(0, 0, 0, 0, '0, 100), 1'b0, reset_view});
    opening_polls.push_back('{key_poll(0, 0, 0, 1, '0, 30), 1'b0, reset_view});
    opening_polls.push_back('{key_poll(0, 0, 0, 0, '0, 0), 1'b0, reset_view});
    // Left and right together cancel.
    opening_polls.push_back('{key_poll(0, 0, 1, 1, '0, 50), 1'b0, reset_view});
    opening_polls.push_back('{key_poll(0, 0, 0, 0, '0, 0), 1'b0, reset_view});
    opening_polls.push_back('{key_poll(0, 1, 0, 0, '0, 20), 1'b0, reset_view});
    opening_polls.push_back('{key_poll(0, 0, 0, 0, '0, 200), 1'b0, reset_view});
    opening_polls.push_back('{key_poll(0, 0, 0, 1, '0, 40), 1'b0, reset_view});
    opening_polls.push_back('{key_poll(0, 0, 0, 0, '0, 0), 1'b0, reset_view});
    // A lone quick key changes speed and closes the menu.
    opening_polls.push_back('{key_poll(0, 0, 0, 0, QUICK_W'(1) << QK_SPEED_UP, 5),
                              1'b0, reset_view});

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (opening_polls[i])
      send_poll(opening_polls[i].poll, opening_polls[i].fixed, opening_polls[i].want);
    wait_drained();

    // Short hold; speed default of zero with junk in the upper data bits.
    reconfigure(16'd300, 16'd2000, 16'hFFFF, 16'h0380, CFG_SPARE_LO, 16'h0007);
    run_polls(200);
    while (!menu_on) send_poll(key_poll(1, 0, 0, 0, '0, 8'hFF), 1'b0, '0);
    wait_drained();

    // Longest hold never toggles the menu; both timers run into saturation.
    reconfigure(16'hFFFF, 16'hFFFF, 16'd0, 16'd127, CFG_SPARE_HI, 16'h0001);
    repeat (270) send_poll(key_poll(1, 0, 0, 0, '0, 8'hFF), 1'b0, '0);
    run_polls(100);
    wait_drained();

    // Zero hold and a window of one millisecond: every blink period is zero.
    reconfigure(16'd0, 16'd1, 16'd1, 16'd1, CFG_SPARE_LO, 16'hFFFF);
    run_polls(150);
    wait_drained();

    // Short window where only small counts get a period.
    reconfigure(16'd150, 16'd20, 16'd0, 16'd100, CFG_SPARE_HI, 16'h0000);
    run_polls(200);
    wait_drained();

    reconfigure(16'd500, 16'd600, 16'd1, 16'd64, CFG_SPARE_LO, 16'h00AA);
    run_polls(250);
    wait_drained();

    reconfigure(16'd255, 16'd2000, 16'd0, 16'd8, CFG_SPARE_HI, 16'hFFFF);
    run_polls(200);
    wait_drained();

    // Allow a stray late beat to show up before the verdict.
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Status receiver: random stalls, each beat checked against the oldest expectation.
  initial begin
    menu_status_t seen;
    menu_status_t want;
    int           stall;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) steady_out = !steady_out;
      stall = steady_out ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      seen = {led_item, led_value, emulation_mode, swap_axes, mouse_speed, setup_active,
              edit_active, menu_item};
      if (status_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: status beat with none expected: %s", $time, show_status(seen));
      end else begin
        want = status_due.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("%0t: status mismatch\n  expected %s\n  actual   %s", $time,
                     show_status(want), show_status(seen));
        end
      end
      @(negedge clk);
    end
  end

  // Watchdog.
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/smbc_pkg.sv
hw/rtl/smbc_div.sv
hw/rtl/smbc_blink.sv
hw/rtl/setup_menu_blink_controller_unit.sv
sim/tb_setup_menu_blink_controller_unit.sv
